### hdl/markup_text_console_writer_unit_defines.svh
// Assertion helpers shared by the console writer RTL.
`ifndef MARKUP_TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH
`define MARKUP_TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define MTCW_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("console writer check failed");

// Next-cycle implication.
`define MTCW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("console writer check failed");

`endif

### hdl/mtcw_pkg.sv
package mtcw_pkg;

  localparam int unsigned MaxCols = 64;
  localparam int unsigned MaxRows = 64;

  localparam int unsigned ColorW  = 16;
  localparam int unsigned DimW    = 7;
  localparam int unsigned PosW    = 6;
  localparam int unsigned CharW   = 8;
  localparam int unsigned OpW     = 3;
  localparam int unsigned CfgIdxW = 3;

  // Opcodes carried in tuser
  localparam logic [OpW-1:0] OP_CHAR      = 3'd0;
  localparam logic [OpW-1:0] OP_BEGIN_POS = 3'd1;
  localparam logic [OpW-1:0] OP_BEGIN_CUR = 3'd2;
  localparam logic [OpW-1:0] OP_END_STR   = 3'd3;
  localparam logic [OpW-1:0] OP_END_LINE  = 3'd4;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_TEXT_COLOR    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SPECIAL_COLOR = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_BG_COLOR      = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_HILITE_COLOR  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_COLUMNS       = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_ROWS          = 3'd5;

  // Markup and control bytes
  localparam logic [CharW-1:0] CH_NUL      = 8'h00;
  localparam logic [CharW-1:0] CH_LF       = 8'h0A;
  localparam logic [CharW-1:0] CH_CR       = 8'h0D;
  localparam logic [CharW-1:0] CH_SPEC_ON  = 8'h5B; // [
  localparam logic [CharW-1:0] CH_SPEC_OFF = 8'h5D; // ]
  localparam logic [CharW-1:0] CH_HIL_ON   = 8'h7B; // {
  localparam logic [CharW-1:0] CH_HIL_OFF  = 8'h7D; // }
  localparam logic [CharW-1:0] CH_UNDER    = 8'h7C; // |

  localparam logic [CharW-1:0] UNDERLINE_BIT = 8'h80;

  localparam logic [DimW-1:0] ColsReset = 7'd32;
  localparam logic [DimW-1:0] RowsReset = 7'd16;

  // Cell write, last field in the lowest bits
  typedef struct packed {
    logic [ColorW-1:0] bg_color;
    logic [ColorW-1:0] fg_color;
    logic [CharW-1:0]  glyph;
    logic [PosW-1:0]   cell_row;
    logic [PosW-1:0]   cell_column;
  } cell_t;

  localparam int unsigned CellW  = $bits(cell_t);
  localparam int unsigned OutW   = ((CellW + 7) / 8) * 8;
  localparam int unsigned InUsed = CharW + 2 * PosW;
  localparam int unsigned InW    = ((InUsed + 7) / 8) * 8;

endpackage

### hdl/markup_text_console_writer_unit.sv
// Channel   Direction  Payload
// s_axis    in         tuser: opcode; tdata: char_code, pos_x, pos_y
// m_axis    out        tdata: cell_column, cell_row, glyph, fg_color, bg_color
// cfg       in         cfg_we_i / cfg_addr_i / cfg_data_i, one register per write
//
// One word is taken per cycle while s_axis is ready; a character's cell write
// is registered into the output register, or into the skid entry while m_axis
// stalls, on the edge that accepts the character, together with cursor and flags.
// A two-entry output (register plus skid) keeps s_axis ready while one result
// waits; s_axis stalls only when both entries are full. Reset is asynchronous,
// active low, clears console state and output valid flags, and resets the configuration.
`include "markup_text_console_writer_unit_defines.svh"

module markup_text_console_writer_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [7:0] char_code, [13:8] pos_x, [19:14] pos_y, rest zero
  input  logic [mtcw_pkg::InW-1:0]          s_axis_tdata,
  // [2:0] opcode
  input  logic [mtcw_pkg::OpW-1:0]          s_axis_tuser,

  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [5:0] cell_column, [11:6] cell_row, [19:12] glyph, [35:20] fg_color,
  // [51:36] bg_color, rest zero
  output logic [mtcw_pkg::OutW-1:0]         m_axis_tdata,

  input  logic                              cfg_we_i,
  input  logic [mtcw_pkg::CfgIdxW-1:0]      cfg_addr_i,
  input  logic [mtcw_pkg::ColorW-1:0]       cfg_data_i
);

  // Configuration
  logic [mtcw_pkg::ColorW-1:0] text_color_q, special_color_q, bg_color_q, hilite_color_q;
  logic [mtcw_pkg::DimW-1:0]   columns_q, rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_color_q    <= '0;
      special_color_q <= '0;
      bg_color_q      <= '0;
      hilite_color_q  <= '0;
      columns_q       <= mtcw_pkg::ColsReset;
      rows_q          <= mtcw_pkg::RowsReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        mtcw_pkg::REG_TEXT_COLOR:    text_color_q    <= cfg_data_i;
        mtcw_pkg::REG_SPECIAL_COLOR: special_color_q <= cfg_data_i;
        mtcw_pkg::REG_BG_COLOR:      bg_color_q      <= cfg_data_i;
        mtcw_pkg::REG_HILITE_COLOR:  hilite_color_q  <= cfg_data_i;
        mtcw_pkg::REG_COLUMNS:       columns_q <= cfg_data_i[mtcw_pkg::DimW-1:0];
        mtcw_pkg::REG_ROWS:          rows_q    <= cfg_data_i[mtcw_pkg::DimW-1:0];
        default: ;
      endcase
    end
  end

  logic [mtcw_pkg::DimW-1:0] eff_cols, eff_rows;
  assign eff_cols = (columns_q > mtcw_pkg::DimW'(mtcw_pkg::MaxCols))
                    ? mtcw_pkg::DimW'(mtcw_pkg::MaxCols) : columns_q;
  assign eff_rows = (rows_q > mtcw_pkg::DimW'(mtcw_pkg::MaxRows))
                    ? mtcw_pkg::DimW'(mtcw_pkg::MaxRows) : rows_q;

  // Console state
  logic [mtcw_pkg::DimW-1:0] cursor_col_q, cursor_col_d;
  logic [mtcw_pkg::PosW-1:0] line_cnt_q, line_cnt_d;
  logic [mtcw_pkg::DimW-1:0] wr_col_q, wr_col_d;
  logic [mtcw_pkg::DimW-1:0] wr_row_q, wr_row_d;
  logic special_q, special_d, hilite_q, hilite_d, under_q, under_d;
  logic active_q, active_d, halted_q, halted_d;

  // Output register plus skid entry
  mtcw_pkg::cell_t out_q, skid_q, cell_word;
  logic            out_valid_q, skid_valid_q;
  logic            s_acc, push;

  assign s_axis_tready = !skid_valid_q;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  logic [mtcw_pkg::OpW-1:0]   op;
  logic [mtcw_pkg::CharW-1:0] ch;
  logic [mtcw_pkg::PosW-1:0]  px, py;
  logic [mtcw_pkg::DimW-1:0]  line_inc, wr_col_inc;
  logic [mtcw_pkg::PosW-1:0]  line_next;

  assign op = s_axis_tuser;
  assign ch = s_axis_tdata[mtcw_pkg::CharW-1:0];
  assign px = s_axis_tdata[mtcw_pkg::CharW +: mtcw_pkg::PosW];
  assign py = s_axis_tdata[mtcw_pkg::CharW + mtcw_pkg::PosW +: mtcw_pkg::PosW];

  // Wrapping line counter step
  assign line_inc   = {1'b0, line_cnt_q} + 7'd1;
  assign line_next  = (line_inc >= eff_rows) ? '0 : line_inc[mtcw_pkg::PosW-1:0];
  assign wr_col_inc = wr_col_q + 7'd1;

  assign cell_word.cell_column = wr_col_q[mtcw_pkg::PosW-1:0];
  assign cell_word.cell_row    = wr_row_q[mtcw_pkg::PosW-1:0];
  assign cell_word.glyph       = under_q ? (ch | mtcw_pkg::UNDERLINE_BIT) : ch;
  assign cell_word.fg_color    = special_q ? special_color_q : text_color_q;
  assign cell_word.bg_color    = hilite_q ? hilite_color_q : bg_color_q;

  always_comb begin
    cursor_col_d = cursor_col_q;
    line_cnt_d   = line_cnt_q;
    wr_col_d     = wr_col_q;
    wr_row_d     = wr_row_q;
    special_d    = special_q;
    hilite_d     = hilite_q;
    under_d      = under_q;
    active_d     = active_q;
    halted_d     = halted_q;
    push         = 1'b0;
    if (s_acc) begin
      case (op)
        mtcw_pkg::OP_BEGIN_POS: begin
          if ({1'b0, px} >= eff_cols || {1'b0, py} >= eff_rows) begin
            active_d = 1'b0;
          end else begin
            wr_col_d     = {1'b0, px};
            wr_row_d     = {1'b0, py};
            cursor_col_d = {1'b0, px};
            special_d    = 1'b0;
            hilite_d     = 1'b0;
            under_d      = 1'b0;
            active_d     = 1'b1;
            halted_d     = 1'b0;
          end
        end
        mtcw_pkg::OP_BEGIN_CUR: begin
          wr_col_d  = cursor_col_q;
          wr_row_d  = {1'b0, line_cnt_q};
          special_d = 1'b0;
          hilite_d  = 1'b0;
          under_d   = 1'b0;
          active_d  = 1'b1;
          halted_d  = 1'b0;
        end
        mtcw_pkg::OP_END_STR: active_d = 1'b0;
        mtcw_pkg::OP_END_LINE: begin
          active_d     = 1'b0;
          line_cnt_d   = line_next;
          cursor_col_d = '0;
        end
        mtcw_pkg::OP_CHAR: begin
          if (!active_q) begin
            // drop bytes outside a string
          end else if (ch == mtcw_pkg::CH_NUL) begin
            active_d = 1'b0;
          end else if (halted_q || wr_col_q >= eff_cols || wr_row_q >= eff_rows) begin
            halted_d = 1'b1;
          end else begin
            case (ch)
              mtcw_pkg::CH_LF, mtcw_pkg::CH_CR: begin
                wr_row_d   = wr_row_q + 7'd1;
                line_cnt_d = line_next;
              end
              mtcw_pkg::CH_SPEC_ON:  special_d = 1'b1;
              mtcw_pkg::CH_SPEC_OFF: special_d = 1'b0;
              mtcw_pkg::CH_HIL_ON:   hilite_d  = 1'b1;
              mtcw_pkg::CH_HIL_OFF:  hilite_d  = 1'b0;
              mtcw_pkg::CH_UNDER:    under_d   = !under_q;
              default: begin
                push         = 1'b1;
                wr_col_d     = wr_col_inc;
                cursor_col_d = wr_col_inc;
              end
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_col_q <= '0;
      line_cnt_q   <= '0;
      wr_col_q     <= '0;
      wr_row_q     <= '0;
      special_q    <= 1'b0;
      hilite_q     <= 1'b0;
      under_q      <= 1'b0;
      active_q     <= 1'b0;
      halted_q     <= 1'b0;
    end else begin
      cursor_col_q <= cursor_col_d;
      line_cnt_q   <= line_cnt_d;
      wr_col_q     <= wr_col_d;
      wr_row_q     <= wr_row_d;
      special_q    <= special_d;
      hilite_q     <= hilite_d;
      under_q      <= under_d;
      active_q     <= active_d;
      halted_q     <= halted_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      // output slot frees: refill from skid first, else from the new word
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push;
      end
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_axis_tready) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (push) begin
        out_q <= cell_word;
      end
    end else if (push) begin
      skid_q <= cell_word;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(mtcw_pkg::OutW - mtcw_pkg::CellW){1'b0}}, out_q};

  `MTCW_ASSERT_IMPL(a_skid_behind_out, skid_valid_q, out_valid_q)
  `MTCW_ASSERT_IMPL(a_cursor_tracks, active_q, cursor_col_q == wr_col_q)
  `MTCW_ASSERT_NEXT(a_push_shows, push, m_axis_tvalid)
  `MTCW_ASSERT_IMPL(a_halt_in_string, push, active_q && !halted_q)

endmodule

### bench/markup_text_console_writer_unit_test.sv
module markup_text_console_writer_unit_test;
  import mtcw_pkg::*;

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned NumPhases  = 9;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [CharW-1:0] code;
    logic [PosW-1:0]  px;
    logic [PosW-1:0]  py;
  } console_word_t;

  logic                 clk_i;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InW-1:0]       s_axis_tdata  = '0;
  logic [OpW-1:0]       s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutW-1:0]      m_axis_tdata;
  logic                 cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]   cfg_addr_i    = '0;
  logic [ColorW-1:0]    cfg_data_i    = '0;

  markup_text_console_writer_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Shadow registers and console state
  logic [ColorW-1:0] text_col, spec_col, back_col, hil_col;
  logic [DimW-1:0]   n_cols, n_rows;
  logic [DimW-1:0]   cur_col, wr_col, wr_row;
  logic [PosW-1:0]   line_cnt;
  bit                spec_on, hil_on, und_on, str_active, str_halted;

  console_word_t     words_to_send[$];
  cell_t             cells_due[$];
  console_word_t     in_flight;
  cell_t             cell_exp;
  cell_t             cell_got;
  bit                word_busy;
  bit                calm;
  int unsigned       send_gap, stall_left;
  int unsigned       mismatches;
  int unsigned       quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned cols_limit();
    return (n_cols > MaxCols) ? MaxCols : n_cols;
  endfunction

  function automatic int unsigned rows_limit();
    return (n_rows > MaxRows) ? MaxRows : n_rows;
  endfunction

  function automatic void next_line();
    int unsigned n;
    n = line_cnt + 1;
    if (n >= rows_limit()) n = 0;
    line_cnt = PosW'(n);
  endfunction

  function automatic void open_string(logic [DimW-1:0] col, logic [DimW-1:0] row);
    wr_col     = col;
    wr_row     = row;
    cur_col    = col;
    spec_on    = 1'b0;
    hil_on     = 1'b0;
    und_on     = 1'b0;
    str_active = 1'b1;
    str_halted = 1'b0;
  endfunction

  // Advance the console by one word; return 1 when it writes a cell.
  function automatic bit predict_cell(input console_word_t w, output cell_t c);
    c = '0;
    case (w.op)
      OP_BEGIN_POS: begin
        if (w.px >= cols_limit() || w.py >= rows_limit()) str_active = 1'b0;
        else open_string({1'b0, w.px}, {1'b0, w.py});
        return 1'b0;
      end
      OP_BEGIN_CUR: begin
        open_string(cur_col, {1'b0, line_cnt});
        return 1'b0;
      end
      OP_END_STR: begin
        str_active = 1'b0;
        return 1'b0;
      end
      OP_END_LINE: begin
        str_active = 1'b0;
        next_line();
        cur_col = '0;
        return 1'b0;
      end
      OP_CHAR: ;
      default: return 1'b0;
    endcase
    if (!str_active) return 1'b0;
    if (w.code == CH_NUL) begin
      str_active = 1'b0;
      return 1'b0;
    end
    if (str_halted || wr_col >= cols_limit() || wr_row >= rows_limit()) begin
      str_halted = 1'b1;
      return 1'b0;
    end
    case (w.code)
      CH_LF, CH_CR: begin
        wr_row = wr_row + 1'b1;
        next_line();
        return 1'b0;
      end
      CH_SPEC_ON:  begin spec_on = 1'b1;    return 1'b0; end
      CH_SPEC_OFF: begin spec_on = 1'b0;    return 1'b0; end
      CH_HIL_ON:   begin hil_on = 1'b1;     return 1'b0; end
      CH_HIL_OFF:  begin hil_on = 1'b0;     return 1'b0; end
      CH_UNDER:    begin und_on = !und_on;  return 1'b0; end
      default: ;
    endcase
    c.cell_column = wr_col[PosW-1:0];
    c.cell_row    = wr_row[PosW-1:0];
    c.glyph       = und_on ? (w.code | UNDERLINE_BIT) : w.code;
    c.fg_color    = spec_on ? spec_col : text_col;
    c.bg_color    = hil_on ? hil_col : back_col;
    wr_col  = wr_col + 1'b1;
    cur_col = wr_col;
    return 1'b1;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [CharW-1:0] pick_char();
    int unsigned r;
    r = $urandom_range(0, 19);
    case (r)
      0: return CH_LF;
      1: return CH_CR;
      2: return CH_SPEC_ON;
      3: return CH_SPEC_OFF;
      4: return CH_HIL_ON;
      5: return CH_HIL_OFF;
      6: return CH_UNDER;
      default: return CharW'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Driver: present one word at a time, predict on acceptance
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
      word_busy = 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (predict_cell(in_flight, cell_exp)) cells_due.push_back(cell_exp);
        word_busy = 1'b0;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0) begin
          send_gap = send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (words_to_send.size() != 0) begin
          in_flight = words_to_send.pop_front();
          word_busy = 1'b1;
          s_axis_tuser  <= in_flight.op;
          s_axis_tdata  <= {{(InW - InUsed){1'b0}}, in_flight.py, in_flight.px, in_flight.code};
          s_axis_tvalid <= 1'b1;
          send_gap = pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each cell write with the oldest prediction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        cell_got = m_axis_tdata[CellW-1:0];
        if (cells_due.size() == 0) begin
          $error("unexpected cell write 0x%0h", cell_got);
          mismatches++;
        end else begin
          cell_exp = cells_due.pop_front();
          check_field("cell_column", cell_exp.cell_column, cell_got.cell_column);
          check_field("cell_row", cell_exp.cell_row, cell_got.cell_row);
          check_field("glyph", cell_exp.glyph, cell_got.glyph);
          check_field("fg_color", cell_exp.fg_color, cell_got.fg_color);
          check_field("bg_color", cell_exp.bg_color, cell_got.bg_color);
        end
      end
      if (stall_left != 0) begin
        stall_left = stall_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("markup_text_console_writer_unit verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_word(input logic [OpW-1:0] op, input logic [CharW-1:0] code,
                            input logic [PosW-1:0] px, input logic [PosW-1:0] py);
    console_word_t w;
    w.op   = op;
    w.code = code;
    w.px   = px;
    w.py   = py;
    words_to_send.push_back(w);
  endtask

  task automatic queue_char(input logic [CharW-1:0] code);
    queue_word(OP_CHAR, code, PosW'($urandom), PosW'($urandom));
  endtask

  task automatic queue_ctrl(input logic [OpW-1:0] op, input logic [PosW-1:0] px,
                            input logic [PosW-1:0] py);
    queue_word(op, CharW'($urandom_range(1, 255)), px, py);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ColorW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_TEXT_COLOR:    text_col = val;
      REG_SPECIAL_COLOR: spec_col = val;
      REG_BG_COLOR:      back_col = val;
      REG_HILITE_COLOR:  hil_col = val;
      REG_COLUMNS:       n_cols = val[DimW-1:0];
      REG_ROWS:          n_rows = val[DimW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Hold until every word is taken and every cell write has arrived
  task automatic drain();
    while (words_to_send.size() != 0 || word_busy || cells_due.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(input int unsigned p);
    logic [DimW-1:0] c, r;
    case (p)
      0: begin c = 7'd64; r = 7'd64; end
      1: begin c = 7'd1;  r = 7'd1;  end
      2: begin c = 7'd1;  r = 7'd64; end
      3: begin c = 7'd64; r = 7'd1;  end
      default: begin
        c = DimW'($urandom_range(1, 64));
        r = DimW'($urandom_range(1, 64));
      end
    endcase
    if (p == 1) begin
      write_reg(REG_TEXT_COLOR, 16'h0000);
      write_reg(REG_SPECIAL_COLOR, 16'hFFFF);
      write_reg(REG_BG_COLOR, 16'hFFFF);
      write_reg(REG_HILITE_COLOR, 16'h0000);
    end else begin
      write_reg(REG_TEXT_COLOR, ColorW'($urandom));
      write_reg(REG_SPECIAL_COLOR, ColorW'($urandom));
      write_reg(REG_BG_COLOR, ColorW'($urandom));
      write_reg(REG_HILITE_COLOR, ColorW'($urandom));
    end
    write_reg(REG_COLUMNS, {9'd0, c});
    write_reg(REG_ROWS, {9'd0, r});
  endtask

  // Mostly well-formed strings with random content, some stray words between them
  task automatic queue_random(input int unsigned budget);
    int unsigned sent, len, r;
    sent = 0;
    while (sent < budget) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        queue_word(OpW'($urandom_range(0, 4)), CharW'($urandom_range(1, 255)),
                   PosW'($urandom), PosW'($urandom));
        sent++;
      end else begin
        if (r < 70)
          queue_ctrl(OP_BEGIN_POS, PosW'($urandom_range(0, cols_limit() - 1)),
                     PosW'($urandom_range(0, rows_limit() - 1)));
        else if (r < 80)
          queue_ctrl(OP_BEGIN_POS, PosW'($urandom), PosW'($urandom));
        else
          queue_ctrl(OP_BEGIN_CUR, PosW'($urandom), PosW'($urandom));
        len = $urandom_range(1, 12);
        repeat (len) queue_char(pick_char());
        sent += len + 1;
        r = $urandom_range(0, 9);
        if (r < 5) begin
          queue_ctrl(OP_END_STR, PosW'($urandom), PosW'($urandom));
          sent++;
        end else if (r < 8) begin
          queue_ctrl(OP_END_LINE, PosW'($urandom), PosW'($urandom));
          sent++;
        end
      end
    end
  endtask

  initial begin
    text_col = '0; spec_col = '0; back_col = '0; hil_col = '0;
    n_cols = ColsReset; n_rows = RowsReset;
    cur_col = '0; wr_col = '0; wr_row = '0; line_cnt = '0;
    spec_on = 1'b0; hil_on = 1'b0; und_on = 1'b0;
    str_active = 1'b0; str_halted = 1'b0;
    mismatches = 0;
    calm = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int unsigned p = 0; p < NumPhases; p++) begin
      drain();
      set_config(p);
      @(negedge clk_i);
      calm = (p == 4 || p == 6);
      if (p == 0) begin
        queue_char("A");                      // no string open: drop
        queue_ctrl(OP_BEGIN_POS, 6'd63, 6'd63);
        queue_char(8'hFF);
        queue_char("B");                      // past the last column: halt
        queue_ctrl(OP_BEGIN_POS, 6'd0, 6'd0);
        queue_char(8'h01);
        queue_char(CH_SPEC_ON);
        queue_char(CH_HIL_ON);
        queue_char(CH_UNDER);
        queue_char("C");
        queue_char(CH_SPEC_OFF);
        queue_char(CH_HIL_OFF);
        queue_char(CH_UNDER);
        queue_char(CH_LF);
        queue_char(CH_CR);
        queue_char("D");
        queue_ctrl(OP_END_LINE, 6'd0, 6'd0);
        queue_ctrl(OP_BEGIN_CUR, 6'd63, 6'd63);
        queue_char("E");
        queue_ctrl(OP_END_STR, 6'd0, 6'd0);
      end else begin
        if (p == 1) begin
          // begin outside a one-cell grid, then line counter wrap
          queue_ctrl(OP_BEGIN_POS, 6'd1, 6'd0);
          queue_char("x");
          queue_ctrl(OP_BEGIN_POS, 6'd0, 6'd1);
          queue_ctrl(OP_BEGIN_POS, 6'd0, 6'd0);
          queue_char("y");
          queue_char("z");
          queue_ctrl(OP_END_LINE, 6'd0, 6'd0);
          queue_ctrl(OP_BEGIN_CUR, 6'd0, 6'd0);
          queue_char("w");
        end
        queue_random(p == 1 ? 50 : 55);
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("markup_text_console_writer_unit verification clean");
    end else begin
      $display("markup_text_console_writer_unit verification failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/mtcw_pkg.sv
hdl/markup_text_console_writer_unit.sv
bench/markup_text_console_writer_unit_test.sv
